/* src/stdp_weight_update_defines.svh */
// Assertion macros for the STDP weight update block.
`ifndef STDP_WEIGHT_UPDATE_DEFINES_SVH
`define STDP_WEIGHT_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define SWU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stdp_weight_update: check failed");
`define SWU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stdp_weight_update: check failed");
`else
`define SWU_ASSERT_IMP(lbl, ante, cons)
`define SWU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* src/swu_pkg.sv */
// Constants and arithmetic helpers for the STDP weight update block.
package swu_pkg;

    localparam int TIME_FRAC_BITS_DEF   = 8;
    localparam int KERNEL_FRAC_BITS_DEF = 15;
    localparam int SHIFT_MS             = 5;
    localparam int LIMIT_MS             = 64;
    localparam logic [3:0] K_TERMS      = 4'd13;

    localparam logic [63:0] DEC16 = 64'd10000000000000000;
    localparam logic [63:0] DEC15 = 64'd1000000000000000;

    // round(num/den * 2^bits), ties up; num below twice den
    function automatic logic [63:0] frac_q(input logic [63:0] num, input logic [63:0] den,
                                           input int bits);
        logic [63:0] res;
        logic [63:0] r;
        int i;
        res = 64'd0;
        r   = num;
        if (r >= den) begin
            r   = r - den;
            res = 64'd1;
        end
        for (i = 0; i < bits; i++) begin
            r   = r << 1;
            res = res << 1;
            if (r >= den) begin
                r      = r - den;
                res[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) begin
            res = res + 64'd1;
        end
        return res;
    endfunction

    localparam logic [63:0] LN2_Q32  = frac_q(64'd6931471805599453, DEC16, 32);
    localparam logic [63:0] L2E_Q30  = frac_q(64'd14426950408889634, DEC16, 30);
    localparam logic [63:0] BDEP_Q32 = frac_q(64'd1331251297482154, DEC16, 32);
    localparam logic [63:0] BPOT_Q32 = frac_q(64'd896464339979975, DEC16, 32);
    localparam logic [63:0] ADEP_Q48 = frac_q(64'd9954616079, DEC15, 48);
    localparam logic [63:0] APOT_Q48 = frac_q(64'd212995136, DEC15, 48);
    localparam logic [63:0] CDEP_Q32 = (BDEP_Q32 * L2E_Q30 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] CPOT_Q32 = (BPOT_Q32 * L2E_Q30 + (64'd1 << 29)) >> 30;

    localparam logic [63:0] RECIP_NUM = 64'd1 << 33;
    localparam logic [7:0]  RECIP_SH  = 8'd33;

    // floor(2^33/k), one below 2^33 for k of one; quotient needs one correction
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] v;
        case (k)
            4'd1:    v = 33'h1_FFFF_FFFF;
            4'd2:    v = 33'(RECIP_NUM / 2);
            4'd3:    v = 33'(RECIP_NUM / 3);
            4'd4:    v = 33'(RECIP_NUM / 4);
            4'd5:    v = 33'(RECIP_NUM / 5);
            4'd6:    v = 33'(RECIP_NUM / 6);
            4'd7:    v = 33'(RECIP_NUM / 7);
            4'd8:    v = 33'(RECIP_NUM / 8);
            4'd9:    v = 33'(RECIP_NUM / 9);
            4'd10:   v = 33'(RECIP_NUM / 10);
            4'd11:   v = 33'(RECIP_NUM / 11);
            4'd12:   v = 33'(RECIP_NUM / 12);
            4'd13:   v = 33'(RECIP_NUM / 13);
            default: v = 33'd0;
        endcase
        return v;
    endfunction

    // (p + 2^(sh-1)) >> sh, or plain truncation
    function automatic logic [39:0] rnd_shift(input logic [65:0] p, input logic [7:0] sh,
                                              input logic trunc);
        logic [66:0] half;
        logic [66:0] s;
        half = trunc ? 67'd0 : (67'd1 << (sh - 8'd1));
        s    = {1'b0, p} + half;
        return 40'(s >> sh);
    endfunction

endpackage

/* src/stdp_weight_update.sv */
// STDP pair-rule weight update for one synapse, built on one shared multiplier.
//
// Channels: requests enter on i_in_valid / o_in_stall and are taken at an edge with
// valid high and stall low. Results leave on o_out_valid / i_out_stall under the same
// rule. The learning amplitude is written on i_cfg_valid / o_cfg_ready, always ready.
// A load request goes straight to DONE. In a spike request that evaluates the kernel,
// every step goes through one 33x33 multiplier with a rounding shifter, 35 products
// in all, 26 of them in the 13-term series for the fractional power of two (each term is a
// multiply and a division by k done as a reciprocal multiply with one correction).
// Requests that evaluate nothing skip the multiplier, and those whose spacing is beyond
// the kernel window stop at the window check.
// The input is stalled while a request is at work. A finished result sits in an
// output register, so the next request is taken while it waits; a second result
// waits in the sequencer until the receiver takes the first.
// Reset clears weight, change flag and output valid, and sets the amplitude to one.
module stdp_weight_update #(
    parameter int TIME_FRAC_BITS   = swu_pkg::TIME_FRAC_BITS_DEF,
    parameter int KERNEL_FRAC_BITS = swu_pkg::KERNEL_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic               i_pre_starts_spike,
    input  logic               i_post_starts_spike,
    input  logic [31:0]        i_pre_spike_time,
    input  logic [31:0]        i_post_spike_time,
    input  logic [31:0]        i_load_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_weight_out,
    output logic               o_changed,
    output logic signed [15:0] o_kernel_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_learn_amplitude
);
    import swu_pkg::*;
    `include "stdp_weight_update_defines.svh"

    localparam logic [32:0] SHIFT_T = 33'(SHIFT_MS << TIME_FRAC_BITS);
    localparam logic [32:0] LIMIT_T = 33'(LIMIT_MS << TIME_FRAC_BITS);
    localparam int          MQ_SH   = 24 - TIME_FRAC_BITS;
    localparam logic [7:0]  SH_W    = 8'd24;
    localparam logic [7:0]  SH_32   = 8'd32;
    localparam logic [7:0]  SH_30   = 8'd30;
    localparam logic [7:0]  SH_HB   = 8'd28;
    localparam logic [7:0]  SH_MAG  = 8'(58 - KERNEL_FRAC_BITS);
    localparam logic [7:0]  SH_DLT  = 8'(KERNEL_FRAC_BITS);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WAIT  = 4'd1;
    localparam logic [3:0] ST_CHK   = 4'd2;
    localparam logic [3:0] ST_WRES  = 4'd3;
    localparam logic [3:0] ST_TRES  = 4'd4;
    localparam logic [3:0] ST_SRES  = 4'd5;
    localparam logic [3:0] ST_DRES  = 4'd6;
    localparam logic [3:0] ST_HRES  = 4'd7;
    localparam logic [3:0] ST_H2RES = 4'd8;
    localparam logic [3:0] ST_H4RES = 4'd9;
    localparam logic [3:0] ST_H8RES = 4'd10;
    localparam logic [3:0] ST_HARES = 4'd11;
    localparam logic [3:0] ST_MRES  = 4'd12;
    localparam logic [3:0] ST_DLRES = 4'd13;
    localparam logic [3:0] ST_DONE  = 4'd14;

    // control
    logic [3:0]  r_st;
    logic [3:0]  r_ret;
    logic        r_ovalid;
    // shared multiplier: operands, rounding shift, product
    logic [32:0] r_opa;
    logic [32:0] r_opb;
    logic [7:0]  r_sh;
    logic        r_trunc;
    logic [65:0] r_prod;
    // per-request working values
    logic        r_dep;
    logic [32:0] r_m;
    logic [30:0] r_mq;
    logic [7:0]  r_n;
    logic [31:0] r_t;
    logic [31:0] r_x;
    logic [32:0] r_sum;
    logic [3:0]  r_k;
    logic [32:0] r_h2;
    logic [15:0] r_mag;
    logic [15:0] r_kern;
    // synapse state and amplitude
    logic [31:0] r_weight;
    logic        r_flag;
    logic [31:0] r_amp;
    // output register
    logic [31:0] r_ow;
    logic        r_oc;
    logic [15:0] r_ok;

    logic [65:0] prod;
    logic [39:0] rnd;
    logic        in_acc;
    logic [32:0] post_sh;
    logic [32:0] pre_ext;
    logic        acc_dep;
    logic [32:0] acc_m;
    logic        acc_eval;
    logic [30:0] mq_c;
    logic [32:0] c_sel;
    logic [32:0] aq_sel;
    logic [31:0] q;
    logic [35:0] qk;
    logic [35:0] rem;
    logic [31:0] n_qc;
    logic [32:0] n_sum;
    logic [15:0] mag_s;
    logic [32:0] delta;
    logic [33:0] wsum;
    logic [31:0] n_weight;

    assign o_in_stall     = (r_st != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ovalid;
    assign o_weight_out   = r_ow;
    assign o_changed      = r_oc;
    assign o_kernel_value = r_ok;

    assign in_acc = i_in_valid && (r_st == ST_IDLE);

    // spike spacing: x = post - pre + shift, sign and magnitude
    assign post_sh  = {1'b0, i_post_spike_time} + SHIFT_T;
    assign pre_ext  = {1'b0, i_pre_spike_time};
    assign acc_dep  = post_sh < pre_ext;
    assign acc_m    = acc_dep ? (pre_ext - post_sh) : (post_sh - pre_ext);
    assign acc_eval = (i_pre_starts_spike || i_post_starts_spike)
                      && (i_pre_spike_time != 32'd0) && (i_post_spike_time != 32'd0);

    assign mq_c   = 31'(64'(r_m) << MQ_SH);
    assign c_sel  = r_dep ? CDEP_Q32[32:0] : CPOT_Q32[32:0];
    assign aq_sel = r_dep ? ADEP_Q48[32:0] : APOT_Q48[32:0];

    assign prod = r_opa * r_opb;
    assign rnd  = rnd_shift(r_prod, r_sh, r_trunc);

    // division by k: reciprocal quotient is low by at most one
    assign q     = rnd[31:0];
    assign qk    = {4'd0, q} * {32'd0, r_k};
    assign rem   = {4'd0, r_x} - qk;
    assign n_qc  = q + {31'd0, (rem >= {32'd0, r_k})};
    assign n_sum = r_k[0] ? (r_sum - {1'b0, n_qc}) : (r_sum + {1'b0, n_qc});

    // clamp kernel magnitude to the Q1.15 range of its sign
    always_comb begin
        if (r_dep) begin
            mag_s = (rnd > 40'd32768) ? 16'h8000 : rnd[15:0];
        end else begin
            mag_s = (rnd > 40'd32767) ? 16'h7FFF : rnd[15:0];
        end
    end

    // weight plus or minus delta, floored at zero and saturated at full scale
    assign delta = rnd[32:0];
    assign wsum  = {2'd0, r_weight} + {1'b0, delta};
    always_comb begin
        if (r_dep) begin
            n_weight = ({1'b0, r_weight} <= delta) ? 32'd0 : (r_weight - delta[31:0]);
        end else begin
            n_weight = (wsum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : wsum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_weight <= 32'd0;
            r_flag   <= 1'b0;
            r_amp    <= 32'd65536;
        end else begin
            if (i_cfg_valid) begin
                r_amp <= i_cfg_learn_amplitude;
            end
            // drop the result once taken; DONE may reload it below
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_kern <= 16'd0;
                        r_dep  <= acc_dep;
                        r_m    <= acc_m;
                        if (i_action) begin
                            r_weight <= i_load_value;
                            r_st     <= ST_DONE;
                        end else if (acc_eval) begin
                            r_st <= ST_CHK;
                        end else begin
                            r_st <= ST_DONE;
                        end
                    end
                end
                ST_WAIT: begin
                    r_st <= r_ret;
                end
                ST_CHK: begin
                    // beyond the window the kernel is zero
                    if (r_m > LIMIT_T) begin
                        r_flag <= 1'b0;
                        r_st   <= ST_DONE;
                    end else begin
                        r_mq    <= mq_c;
                        r_opa   <= {2'd0, mq_c};
                        r_opb   <= c_sel;
                        r_sh    <= SH_W;
                        r_trunc <= 1'b0;
                        r_ret   <= ST_WRES;
                        r_st    <= ST_WAIT;
                    end
                end
                ST_WRES: begin
                    // integer part to the final shift, fraction on to 2^-f
                    r_n     <= rnd[39:32];
                    r_opa   <= {1'b0, rnd[31:0]};
                    r_opb   <= {1'b0, LN2_Q32[31:0]};
                    r_sh    <= SH_32;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_TRES;
                    r_st    <= ST_WAIT;
                end
                ST_TRES: begin
                    r_t     <= rnd[31:0];
                    r_sum   <= 33'h1_0000_0000;
                    r_k     <= 4'd1;
                    r_opa   <= 33'h1_0000_0000;
                    r_opb   <= {1'b0, rnd[31:0]};
                    r_sh    <= SH_32;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_SRES;
                    r_st    <= ST_WAIT;
                end
                ST_SRES: begin
                    r_x     <= rnd[31:0];
                    r_opa   <= {1'b0, rnd[31:0]};
                    r_opb   <= recip(r_k);
                    r_sh    <= RECIP_SH;
                    r_trunc <= 1'b1;
                    r_ret   <= ST_DRES;
                    r_st    <= ST_WAIT;
                end
                ST_DRES: begin
                    r_sum   <= n_sum;
                    r_trunc <= 1'b0;
                    r_st    <= ST_WAIT;
                    if (r_k == K_TERMS) begin
                        r_opa <= {2'd0, r_mq};
                        r_opb <= n_sum;
                        r_sh  <= SH_HB + r_n;
                        r_ret <= ST_HRES;
                    end else begin
                        r_k   <= r_k + 4'd1;
                        r_opa <= {1'b0, n_qc};
                        r_opb <= {1'b0, r_t};
                        r_sh  <= SH_32;
                        r_ret <= ST_SRES;
                    end
                end
                ST_HRES: begin
                    r_opa   <= rnd[32:0];
                    r_opb   <= rnd[32:0];
                    r_sh    <= SH_30;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_H2RES;
                    r_st    <= ST_WAIT;
                end
                ST_H2RES: begin
                    r_h2    <= rnd[32:0];
                    r_opa   <= rnd[32:0];
                    r_opb   <= rnd[32:0];
                    r_sh    <= SH_30;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_H4RES;
                    r_st    <= ST_WAIT;
                end
                ST_H4RES: begin
                    r_opa   <= rnd[32:0];
                    r_opb   <= rnd[32:0];
                    r_sh    <= SH_30;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_H8RES;
                    r_st    <= ST_WAIT;
                end
                ST_H8RES: begin
                    r_opa   <= rnd[32:0];
                    r_opb   <= r_h2;
                    r_sh    <= SH_30;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_HARES;
                    r_st    <= ST_WAIT;
                end
                ST_HARES: begin
                    r_opa   <= aq_sel;
                    r_opb   <= rnd[32:0];
                    r_sh    <= SH_MAG;
                    r_trunc <= 1'b0;
                    r_ret   <= ST_MRES;
                    r_st    <= ST_WAIT;
                end
                ST_MRES: begin
                    r_mag <= mag_s;
                    if (mag_s == 16'd0) begin
                        r_flag <= 1'b0;
                        r_st   <= ST_DONE;
                    end else begin
                        r_opa   <= {1'b0, r_amp};
                        r_opb   <= {17'd0, mag_s};
                        r_sh    <= SH_DLT;
                        r_trunc <= 1'b0;
                        r_ret   <= ST_DLRES;
                        r_st    <= ST_WAIT;
                    end
                end
                ST_DLRES: begin
                    r_weight <= n_weight;
                    r_flag   <= 1'b1;
                    r_kern   <= r_dep ? 16'(16'd0 - r_mag) : r_mag;
                    r_st     <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_ow     <= r_weight;
                        r_oc     <= r_flag;
                        r_ok     <= r_kern;
                        r_st     <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    `SWU_ASSERT_NXT(a_load_to_done, in_acc && i_action, r_st == ST_DONE)
    `SWU_ASSERT_IMP(a_k_range, r_st == ST_DRES, r_k != 4'd0 && r_k <= K_TERMS)
    `SWU_ASSERT_IMP(a_div_corr, r_st == ST_DRES, rem < {31'd0, r_k, 1'b0})
    `SWU_ASSERT_IMP(a_kern_sign, r_st == ST_DONE && r_kern != 16'd0, r_kern[15] == r_dep)
    `SWU_ASSERT_IMP(a_kern_flag, o_out_valid && o_kernel_value != 16'sd0, o_changed)

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the STDP pair-rule weight update block.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic        action;
        logic        pre_go;
        logic        post_go;
        logic [31:0] pre_t;
        logic [31:0] post_t;
        logic [31:0] load;
    } spike_req_t;

    typedef struct packed {
        logic [31:0]        weight;
        logic               changed;
        logic signed [15:0] kernel;
    } weight_res_t;

    localparam int          TFRAC   = swu_pkg::TIME_FRAC_BITS_DEF;
    localparam int          KFRAC   = swu_pkg::KERNEL_FRAC_BITS_DEF;
    localparam logic [63:0] SHIFT_T = 64'(swu_pkg::SHIFT_MS) << TFRAC;
    localparam logic [63:0] LIMIT_T = 64'(swu_pkg::LIMIT_MS) << TFRAC;
    localparam logic [63:0] TEN16   = 64'd10000000000000000;
    localparam logic [63:0] TEN15   = 64'd1000000000000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic               i_pre_starts_spike;
    logic               i_post_starts_spike;
    logic [31:0]        i_pre_spike_time;
    logic [31:0]        i_post_spike_time;
    logic [31:0]        i_load_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [31:0]        o_weight_out;
    logic               o_changed;
    logic signed [15:0] o_kernel_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_learn_amplitude;

    spike_req_t  pending_reqs[$];
    weight_res_t expected_weights[$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    // predictor state
    logic [31:0] model_weight = 32'd0;
    logic        model_flag = 1'b0;
    logic [31:0] model_amp = 32'd65536;

    stdp_weight_update u_top (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // round(num/den * 2^bits), ties up, by long division
    function automatic logic [63:0] div_frac(input logic [63:0] num, input logic [63:0] den,
                                             input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < bits; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) q = q + 64'd1;
        return q;
    endfunction

    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        return (a * b + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // magnitude of a*x^10*exp(-10*b*x) in kernel Q format, before saturation
    function automatic logic [63:0] kernel_magnitude(input logic [63:0] m_t, input logic dep);
        logic [63:0] mq, l2e, bq, aq, c, w, f, ln2, t, sum, term, h, h2, h4, h8, h10;
        int          n;
        mq   = m_t << (24 - TFRAC);
        l2e  = div_frac(64'd14426950408889634, TEN16, 30);
        bq   = dep ? div_frac(64'd1331251297482154, TEN16, 32)
                   : div_frac(64'd896464339979975, TEN16, 32);
        aq   = dep ? div_frac(64'd9954616079, TEN15, 48) : div_frac(64'd212995136, TEN15, 48);
        c    = mul_round(bq, l2e, 30);
        w    = mul_round(mq, c, 24);
        n    = int'(w >> 32);
        f    = w & 64'hFFFF_FFFF;
        ln2  = div_frac(64'd6931471805599453, TEN16, 32);
        t    = mul_round(f, ln2, 32);
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 13; k++) begin
            term = mul_round(term, t, 32) / 64'(k);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        h   = mul_round(mq, sum, 28 + n);
        h2  = mul_round(h, h, 30);
        h4  = mul_round(h2, h2, 30);
        h8  = mul_round(h4, h4, 30);
        h10 = mul_round(h8, h2, 30);
        return mul_round(aq, h10, 58 - KFRAC);
    endfunction

    // advance the predicted synapse state by one request
    function automatic weight_res_t apply_request(input spike_req_t rq);
        weight_res_t res;
        logic        dep;
        logic [63:0] m, mag, delta, total;
        res.kernel = 16'sd0;
        if (rq.action) begin
            model_weight = rq.load;
        end else if ((rq.pre_go || rq.post_go) && rq.pre_t != 0 && rq.post_t != 0) begin
            dep = (64'(rq.post_t) + SHIFT_T) < 64'(rq.pre_t);
            m   = dep ? 64'(rq.pre_t) - 64'(rq.post_t) - SHIFT_T
                      : 64'(rq.post_t) + SHIFT_T - 64'(rq.pre_t);
            mag = (m <= LIMIT_T) ? kernel_magnitude(m, dep) : 64'd0;
            if (dep && mag > 64'd32768) mag = 64'd32768;
            if (!dep && mag > 64'd32767) mag = 64'd32767;
            if (mag != 0) begin
                delta = (64'(model_amp) * mag + (64'd1 << (KFRAC - 1))) >> KFRAC;
                model_flag = 1'b1;
                if (dep) begin
                    model_weight = (delta >= 64'(model_weight)) ? 32'd0
                                                                : 32'(64'(model_weight) - delta);
                end else begin
                    total = 64'(model_weight) + delta;
                    model_weight = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
                end
            end else begin
                model_flag = 1'b0;
            end
            res.kernel = dep ? 16'(-mag) : 16'(mag);
        end
        res.weight  = model_weight;
        res.changed = model_flag;
        return res;
    endfunction

    // request driver: hold the payload while stalled, advance on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) expected_weights.push_back(apply_request(
                '{i_action, i_pre_starts_spike, i_post_starts_spike, i_pre_spike_time,
                  i_post_spike_time, i_load_value}));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    spike_req_t rq;
                    rq = pending_reqs.pop_front();
                    i_in_valid          <= 1'b1;
                    i_action            <= rq.action;
                    i_pre_starts_spike  <= rq.pre_go;
                    i_post_starts_spike <= rq.post_go;
                    i_pre_spike_time    <= rq.pre_t;
                    i_post_spike_time   <= rq.post_t;
                    i_load_value        <= rq.load;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_weights.size() == 0) begin
                    $display("%0t: unexpected result weight=%h changed=%b kernel=%0d", $time,
                             o_weight_out, o_changed, o_kernel_value);
                    errors++;
                end else begin
                    weight_res_t ex;
                    ex = expected_weights.pop_front();
                    if (ex.weight !== o_weight_out) begin
                        $display("%0t: weight expected %h actual %h", $time, ex.weight,
                                 o_weight_out);
                        errors++;
                    end
                    if (ex.changed !== o_changed) begin
                        $display("%0t: changed expected %b actual %b", $time, ex.changed,
                                 o_changed);
                        errors++;
                    end
                    if (ex.kernel !== o_kernel_value) begin
                        $display("%0t: kernel expected %0d actual %0d", $time, ex.kernel,
                                 o_kernel_value);
                        errors++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic spike_req_t make_event(input logic pg, input logic qg,
                                              input logic [31:0] pre, input logic [31:0] post);
        return '{1'b0, pg, qg, pre, post, $urandom()};
    endfunction

    // random request, mostly spike pairs inside the kernel window
    function automatic spike_req_t random_request();
        spike_req_t  rq;
        int          sel;
        logic [31:0] pre;
        int          dt;
        sel = $urandom_range(0, 99);
        pre = $urandom_range(32'd20000, 32'hFFFF0000);
        if ($urandom_range(0, 3) == 0) pre = $urandom_range(32'd20000, 32'd200000);
        rq  = make_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pre, 32'd0);
        if (!rq.pre_go && !rq.post_go) begin
            if ($urandom_range(0, 9) != 0) rq.post_go = 1'b1;
        end
        if (sel < 14) begin
            rq.action = 1'b1;
            rq.pre_t  = $urandom();
            rq.post_t = $urandom();
            case ($urandom_range(0, 3))
                0: rq.load = $urandom_range(0, 32'd100000);
                1: rq.load = 32'hFFFF_FFFF - $urandom_range(0, 32'd100000);
                default: rq.load = $urandom();
            endcase
        end else if (sel < 22) begin
            rq.pre_t  = $urandom();
            rq.post_t = $urandom();
            if ($urandom_range(0, 1)) rq.pre_t = 32'd0;
            else rq.post_t = 32'd0;
        end else if (sel < 30) begin
            rq.post_t = $urandom();
            if (rq.post_t == 0) rq.post_t = 32'd1;
        end else begin
            dt = $urandom_range(0, 129 * 256) - 69 * 256 - 256;
            rq.post_t = pre + dt;
        end
        return rq;
    endfunction

    task automatic write_amplitude(input logic [31:0] amp);
        @(posedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_learn_amplitude <= amp;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_amp = amp;
        i_cfg_valid <= 1'b0;
    endtask

    // hold until every request is taken and every result checked, then let the block settle
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_weights.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] amps[5];
        int          idle_of[4];
        int          stall_of[4];
        logic [31:0] b;
        amps     = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0};
        idle_of  = '{0, 60, 0, 24};
        stall_of = '{0, 0, 60, 24};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_pre_starts_spike = 1'b0;
        i_post_starts_spike = 1'b0;
        i_pre_spike_time = 32'd0;
        i_post_spike_time = 32'd0;
        i_load_value = 32'd0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_learn_amplitude = 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the fields, window limits, clamping and ignored events
        b = 32'd100000;
        pending_reqs.push_back('{1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
        pending_reqs.push_back(make_event(1'b1, 1'b0, b, b + 6 * 256));
        pending_reqs.push_back(make_event(1'b1, 1'b1, b, b - 5 * 256));
        pending_reqs.push_back(make_event(1'b0, 1'b1, b, b - 5 * 256 - 1));
        pending_reqs.push_back(make_event(1'b0, 1'b1, b, b - 13 * 256));
        pending_reqs.push_back(make_event(1'b1, 1'b0, b, b + 59 * 256));
        pending_reqs.push_back(make_event(1'b1, 1'b0, b, b + 59 * 256 + 1));
        pending_reqs.push_back(make_event(1'b0, 1'b1, b, b - 69 * 256));
        pending_reqs.push_back(make_event(1'b0, 1'b1, b, b - 69 * 256 - 1));
        pending_reqs.push_back(make_event(1'b0, 1'b0, b, b + 6 * 256));
        pending_reqs.push_back(make_event(1'b1, 1'b1, 32'd0, b));
        pending_reqs.push_back(make_event(1'b1, 1'b1, b, 32'd0));
        pending_reqs.push_back(make_event(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_event(1'b1, 1'b1, 32'd1, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_event(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_F000));
        pending_reqs.push_back('{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF});
        pending_reqs.push_back(make_event(1'b1, 1'b0, b, b + 6 * 256));
        pending_reqs.push_back('{1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd3});
        pending_reqs.push_back(make_event(1'b0, 1'b1, b, b - 12 * 256));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_amplitude(ph == 4 ? $urandom() : amps[ph]);
            idle_pct  = idle_of[ph % 4];
            stall_pct = stall_of[ph % 4];
            for (int i = 0; i < 390; i++) pending_reqs.push_back(random_request());
            drain();
        end

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
